// ===== rtl/mf3_pkg.sv =====
`default_nettype none
package mf3_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE = 3;

	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W = NUM_CH * CH_W;
	localparam int TAPS = 9;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = HEIGHT_REG_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [CH_W-1:0] chan0;
		logic [CH_W-1:0] chan1;
		logic [CH_W-1:0] chan2;
		logic            frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0]  med0;
		logic [CH_W-1:0]  med1;
		logic [CH_W-1:0]  med2;
		logic [COL_W-1:0] center_col;
		logic [ROW_W-1:0] center_row;
		logic             frame_end;
	} med_out_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} stage_en_t;

	typedef logic [TAPS-1:0][CH_W-1:0] taps_t;

endpackage
`default_nettype wire

// ===== rtl/mf3_line_store.sv =====
`default_nettype none
module mf3_line_store
	import mf3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic [COL_W-1:0]     rd_addr,
	output logic      [2*PIX_W-1:0]   rd_data,
	input  wire logic                 wr_en,
	input  wire logic [COL_W-1:0]     wr_addr,
	input  wire logic [2*PIX_W-1:0]   wr_data
);

	// {line two above, line above} per column
	logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mf3_med9.sv =====
`default_nettype none
module mf3_med9
	import mf3_pkg::*;
(
	input  wire logic            clk,
	input  wire stage_en_t       en,
	input  wire taps_t           taps,
	output logic      [CH_W-1:0] med
);

	typedef logic [2:0][CH_W-1:0] trio_t;

	function automatic trio_t sort3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
			input logic [CH_W-1:0] c);
		logic [CH_W-1:0] x, y, y2, hi;
		trio_t r;
		x  = (a < b) ? a : b;
		y  = (a < b) ? b : a;
		y2 = (y < c) ? y : c;
		hi = (y < c) ? c : y;
		r[0] = (x < y2) ? x : y2;
		r[1] = (x < y2) ? y2 : x;
		r[2] = hi;
		return r;
	endfunction

	logic [2:0][CH_W-1:0] lo_s2, mi_s2, hi_s2;
	logic [CH_W-1:0] a_s3, b_s3, c_s3;
	trio_t srt [3];
	trio_t lo_srt, mi_srt, hi_srt, fin_srt;

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			srt[g] = sort3(taps[3*g], taps[3*g+1], taps[3*g+2]);
		end
		lo_srt = sort3(lo_s2[0], lo_s2[1], lo_s2[2]);
		mi_srt = sort3(mi_s2[0], mi_s2[1], mi_s2[2]);
		hi_srt = sort3(hi_s2[0], hi_s2[1], hi_s2[2]);
		fin_srt = sort3(a_s3, b_s3, c_s3);
	end

	// column sort
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			for (int g = 0; g < 3; g++) begin
				lo_s2[g] <= srt[g][0];
				mi_s2[g] <= srt[g][1];
				hi_s2[g] <= srt[g][2];
			end
		end
	end

	// max of lows, median of mids, min of highs
	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			a_s3 <= lo_srt[2];
			b_s3 <= mi_srt[1];
			c_s3 <= hi_srt[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_out) begin
			med <= fin_srt[1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/median_filter_3x3_rgb_top.sv =====
// 3x3 per-channel median filter over a raster pixel stream.
// A result passes the stage 1, column sort, max/median/min and output registers in turn.
// One pixel per cycle unless out_ready stalls; line store read and written once per pixel.
// Reset: clears position counters, pipeline valids and size registers (640x480).
// Line store and window contents are not cleared; no clearing pass after reset.
`default_nettype none
module median_filter_3x3_rgb_top
	import mf3_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire pix_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output med_out_t                   out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WIDTH_REG_W-1:0] w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	logic [COL_W-1:0] col_q, col_use, cc0;
	logic [ROW_W-1:0] row_q, row_use, cr0;
	logic [COL_W:0] col_inc;
	logic [ROW_W:0] row_inc;
	logic col_wrap, row_wrap, res0, fe0;

	logic in_fire, adv_s1, free_s1, free_s2, free_s3;
	stage_en_t en;

	logic v_s1, res_s1, fe_s1;
	logic [PIX_W-1:0] px_s1;
	logic [COL_W-1:0] addr_s1, cc_s1;
	logic [ROW_W-1:0] cr_s1;

	logic v_s2, fe_s2, v_s3, fe_s3, fe_q;
	logic [COL_W-1:0] cc_s2, cc_s3, cc_q;
	logic [ROW_W-1:0] cr_s2, cr_s3, cr_q;
	logic out_v_q;

	logic [2*PIX_W-1:0] rd_data, rd_eff, wr_data, fwd_data_q;
	logic fwd_q;
	logic [PIX_W-1:0] up1, up2;
	logic [5:0][PIX_W-1:0] win_q;

	logic [CH_W-1:0] med [NUM_CH];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(640);
			height_q <= HEIGHT_REG_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q <= cfg_data[WIDTH_REG_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_REG_W'(MIN_SIZE))
			w_eff = WIDTH_REG_W'(MIN_SIZE);
		else if (width_q > WIDTH_REG_W'(MAX_WIDTH))
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q < HEIGHT_REG_W'(MIN_SIZE))
			h_eff = HEIGHT_REG_W'(MIN_SIZE);
		else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT))
			h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// handshake chain
	assign en.ld_out = v_s3 && (!out_v_q || out_ready);
	assign free_s3   = !v_s3 || en.ld_out;
	assign en.ld_s3  = v_s2 && free_s3;
	assign free_s2   = !v_s2 || en.ld_s3;
	assign adv_s1    = v_s1 && (!res_s1 || free_s2);
	assign en.ld_s2  = adv_s1 && res_s1;
	assign free_s1   = !v_s1 || adv_s1;
	assign in_ready  = free_s1;
	assign in_fire   = in_valid && in_ready;

	// position
	always_comb begin
		col_use  = in_data.frame_start ? '0 : col_q;
		row_use  = in_data.frame_start ? '0 : row_q;
		col_inc  = {1'b0, col_use} + 1'b1;
		row_inc  = {1'b0, row_use} + 1'b1;
		col_wrap = col_inc >= (COL_W+1)'(w_eff);
		row_wrap = row_inc >= (ROW_W+1)'(h_eff);
		res0     = (row_use >= ROW_W'(2)) && (col_use >= COL_W'(2));
		cc0      = col_use - 1'b1;
		cr0      = row_use - 1'b1;
		fe0      = ({1'b0, cr0} == h_eff - HEIGHT_REG_W'(2))
			&& ({1'b0, cc0} == w_eff - WIDTH_REG_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_use;
			end
		end
	end

	// stage 1: line store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1      <= {in_data.chan2, in_data.chan1, in_data.chan0};
			addr_s1    <= col_use;
			res_s1     <= res0;
			cc_s1      <= cc0;
			cr_s1      <= cr0;
			fe_s1      <= fe0;
			fwd_data_q <= wr_data;
		end
	end

	// same column read while the older pixel writes back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (in_fire) begin
			fwd_q <= adv_s1 && (col_use == addr_s1);
		end
	end

	assign rd_eff  = fwd_q ? fwd_data_q : rd_data;
	assign up2     = rd_eff[2*PIX_W-1:PIX_W];
	assign up1     = rd_eff[PIX_W-1:0];
	assign wr_data = {up1, px_s1};

	mf3_line_store u_line_store (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_use),
		.rd_data (rd_data),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up2;
			win_q[4] <= up1;
			win_q[5] <= px_s1;
		end
	end

	// median per channel
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		taps_t ch_taps;

		always_comb begin
			for (int t = 0; t < 6; t++) begin
				ch_taps[t] = win_q[t][ch*CH_W +: CH_W];
			end
			ch_taps[6] = up2[ch*CH_W +: CH_W];
			ch_taps[7] = up1[ch*CH_W +: CH_W];
			ch_taps[8] = px_s1[ch*CH_W +: CH_W];
		end

		mf3_med9 u_med9 (
			.clk  (clk),
			.en   (en),
			.taps (ch_taps),
			.med  (med[ch])
		);
	end

	// result position alongside the sorter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en.ld_s2)
				v_s2 <= 1'b1;
			else if (en.ld_s3)
				v_s2 <= 1'b0;
			if (en.ld_s3)
				v_s3 <= 1'b1;
			else if (en.ld_out)
				v_s3 <= 1'b0;
			if (en.ld_out)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			cc_s2 <= cc_s1;
			cr_s2 <= cr_s1;
			fe_s2 <= fe_s1;
		end
		if (en.ld_s3) begin
			cc_s3 <= cc_s2;
			cr_s3 <= cr_s2;
			fe_s3 <= fe_s2;
		end
		if (en.ld_out) begin
			cc_q <= cc_s3;
			cr_q <= cr_s3;
			fe_q <= fe_s3;
		end
	end

	assign out_valid           = out_v_q;
	assign out_data.med0       = med[0];
	assign out_data.med1       = med[1];
	assign out_data.med2       = med[2];
	assign out_data.center_col = cc_q;
	assign out_data.center_row = cr_q;
	assign out_data.frame_end  = fe_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && adv_s1 && (col_use == addr_s1)) |=> fwd_q)
		else $error("line store forwarding missed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.center_col != '0) && (out_data.center_row != '0))
		else $error("border pixel produced a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_end) |->
			({1'b0, out_data.center_col} == w_eff - WIDTH_REG_W'(2)))
		else $error("frame end on wrong column");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && res_s1 && v_s2)
		else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire
